@@ hdl/pqd_pkg.sv @@
// ---------------------------------------------------------------------------
// pqd_pkg
// shared constants and types for the packed quaternion decoder
// ---------------------------------------------------------------------------
package pqd_pkg;

   localparam int FRAC_BITS = 16;
   localparam int LANES     = 4;
   localparam int XY_SCALE  = 1023;
   localparam int Z_SCALE   = 511;

   // lane order through the divide and root pipelines
   localparam int LANE_W = 0;
   localparam int LANE_X = 1;
   localparam int LANE_Y = 2;
   localparam int LANE_Z = 3;

   localparam int MAG_W    = 11;                  // |component| before scaling
   localparam int PROD_W   = 20;                  // |component| times the other scale
   localparam int D_W      = 2 * PROD_W;          // divisor, squared length
   localparam int Q_W      = 2 * FRAC_BITS + 3;   // quotient bits
   localparam int N_W      = D_W + Q_W;           // dividend bits
   localparam int SQ_STEPS = (Q_W + 1) / 2;       // root digits
   localparam int ROOT_W   = SQ_STEPS;
   localparam int REM_W    = SQ_STEPS + 1;
   localparam int QV_W     = 18;                  // vector part field
   localparam int QW_W     = 17;                  // w field

   localparam int NORM_SHIFT  = 2 * FRAC_BITS + 2;
   localparam int PLAIN_SHIFT = FRAC_BITS + 1;

   localparam logic [D_W-1:0] FULL_DEN =
      D_W'(64'(XY_SCALE) * 64'(XY_SCALE) * 64'(Z_SCALE) * 64'(Z_SCALE));

   typedef logic [N_W-1:0]    dvd_type;
   typedef logic [D_W-1:0]    dsr_type;
   typedef logic [Q_W-1:0]    quo_type;
   typedef logic [ROOT_W-1:0] root_type;

   typedef struct packed {
      logic [2:0] neg;    // sign of x, y, z
      logic       norm;   // squared length reached one
      logic       last;
   } side_type;

endpackage

@@ hdl/pqd_if.sv @@
// ---------------------------------------------------------------------------
// pqd_if
// valid/ready channels of the packed quaternion decoder
// ---------------------------------------------------------------------------
interface pqd_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] packed_word;
   logic        last_row;
   modport source (output valid, packed_word, last_row, input ready);
   modport sink   (input valid, packed_word, last_row, output ready);
endinterface

interface pqd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] quat_w;
   logic signed [17:0] quat_x;
   logic signed [17:0] quat_y;
   logic signed [17:0] quat_z;
   logic               was_normalized;
   logic               last_out;
   modport source (output valid, quat_w, quat_x, quat_y, quat_z, was_normalized, last_out,
                   input ready);
   modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, was_normalized, last_out,
                   output ready);
endinterface

@@ hdl/pqd_front.sv @@
// ---------------------------------------------------------------------------
// pqd_front
// unpack, square, length test and dividend/divisor setup (four stages)
// ---------------------------------------------------------------------------
module pqd_front import pqd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  logic [31:0] in_word,
   input  logic     in_last,
   output logic     out_valid,
   input  logic     out_ready,
   output dvd_type  out_n [LANES],
   output dsr_type  out_d [LANES],
   output side_type out_side
);

   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   logic [MAG_W-1:0]  mag_in [3];
   logic [PROD_W-1:0] a_in   [3];
   logic [2:0]        neg_in;
   logic [11:0]       xs, ys;
   logic [10:0]       zs;

   logic [MAG_W-1:0]  mag1_ff [3];
   logic [PROD_W-1:0] a1_ff   [3];
   side_type          side1_ff;

   logic [MAG_W-1:0]  mag2_ff [3];
   logic [D_W-1:0]    sq2_ff  [3];
   side_type          side2_ff;

   logic [MAG_W-1:0]  mag3_ff [3];
   logic [D_W-1:0]    sq3_ff  [3];
   logic [D_W-1:0]    num3_in;
   logic [D_W-1:0]    num3_ff;
   side_type          side3_ff;

   dvd_type           n4_in  [LANES];
   dsr_type           d4_in  [LANES];
   dvd_type           n4_ff  [LANES];
   dsr_type           d4_ff  [LANES];
   side_type          side4_ff;
   logic [D_W-1:0]    rest;

   assign rdy4     = !s4_v_ff || out_ready;
   assign rdy3     = !s3_v_ff || rdy4;
   assign rdy2     = !s2_v_ff || rdy3;
   assign rdy1     = !s1_v_ff || rdy2;
   assign in_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         if (rdy1) s1_v_ff <= in_valid;
         if (rdy2) s2_v_ff <= s1_v_ff;
         if (rdy3) s3_v_ff <= s2_v_ff;
         if (rdy4) s4_v_ff <= s3_v_ff;
      end
   end

   // stage 1: signed components, magnitudes, scaled magnitudes
   always_comb begin
      xs = 12'(XY_SCALE) - {1'b0, in_word[10:0]};
      ys = 12'(XY_SCALE) - {1'b0, in_word[21:11]};
      zs = 11'(Z_SCALE) - {1'b0, in_word[31:22]};
      neg_in = {zs[10], ys[11], xs[11]};
      mag_in[0] = xs[11] ? MAG_W'(-xs) : xs[MAG_W-1:0];
      mag_in[1] = ys[11] ? MAG_W'(-ys) : ys[MAG_W-1:0];
      mag_in[2] = zs[10] ? MAG_W'(-zs) : zs[MAG_W-1:0];
      a_in[0] = PROD_W'(PROD_W'(mag_in[0]) * PROD_W'(Z_SCALE));
      a_in[1] = PROD_W'(PROD_W'(mag_in[1]) * PROD_W'(Z_SCALE));
      a_in[2] = PROD_W'(PROD_W'(mag_in[2]) * PROD_W'(XY_SCALE));
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         mag1_ff       <= mag_in;
         a1_ff         <= a_in;
         side1_ff.neg  <= neg_in;
         side1_ff.norm <= 1'b0;
         side1_ff.last <= in_last;
      end
   end

   // stage 2: squares
   always_ff @(posedge clock) begin
      if (rdy2) begin
         for (int i = 0; i < 3; i++) begin
            sq2_ff[i] <= D_W'(D_W'(a1_ff[i]) * D_W'(a1_ff[i]));
         end
         mag2_ff  <= mag1_ff;
         side2_ff <= side1_ff;
      end
   end

   // stage 3: squared length and the compare with one
   assign num3_in = sq2_ff[0] + sq2_ff[1] + sq2_ff[2];

   always_ff @(posedge clock) begin
      if (rdy3) begin
         num3_ff       <= num3_in;
         sq3_ff        <= sq2_ff;
         mag3_ff       <= mag2_ff;
         side3_ff.neg  <= side2_ff.neg;
         side3_ff.last <= side2_ff.last;
         side3_ff.norm <= (num3_in >= FULL_DEN);
      end
   end

   // stage 4: one dividend and divisor per lane
   always_comb begin
      rest = FULL_DEN - num3_ff;
      if (side3_ff.norm) begin
         n4_in[LANE_W] = '0;
         for (int i = 0; i < 3; i++) begin
            n4_in[i+1] = N_W'(sq3_ff[i]) << NORM_SHIFT;
            d4_in[i+1] = num3_ff;
         end
      end else begin
         n4_in[LANE_W] = N_W'(rest) << NORM_SHIFT;
         n4_in[LANE_X] = (N_W'(mag3_ff[0]) << PLAIN_SHIFT) + N_W'(XY_SCALE);
         n4_in[LANE_Y] = (N_W'(mag3_ff[1]) << PLAIN_SHIFT) + N_W'(XY_SCALE);
         n4_in[LANE_Z] = (N_W'(mag3_ff[2]) << PLAIN_SHIFT) + N_W'(Z_SCALE);
         d4_in[LANE_X] = D_W'(2 * XY_SCALE);
         d4_in[LANE_Y] = D_W'(2 * XY_SCALE);
         d4_in[LANE_Z] = D_W'(2 * Z_SCALE);
      end
      d4_in[LANE_W] = FULL_DEN;
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         n4_ff    <= n4_in;
         d4_ff    <= d4_in;
         side4_ff <= side3_ff;
      end
   end

   assign out_valid = s4_v_ff;
   assign out_n     = n4_ff;
   assign out_d     = d4_ff;
   assign out_side  = side4_ff;

endmodule

@@ hdl/pqd_div.sv @@
// ---------------------------------------------------------------------------
// pqd_div
// restoring divider, one quotient bit per stage, four lanes in lockstep
// ---------------------------------------------------------------------------
module pqd_div import pqd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  dvd_type  in_n [LANES],
   input  dsr_type  in_d [LANES],
   input  side_type in_side,
   output logic     out_valid,
   input  logic     out_ready,
   output quo_type  out_q [LANES],
   output side_type out_side
);

   logic     v_ff    [Q_W];
   logic     rdy     [Q_W+1];
   dsr_type  r_ff    [Q_W][LANES];
   quo_type  lo_ff   [Q_W][LANES];
   dsr_type  d_ff    [Q_W][LANES];
   side_type side_ff [Q_W];

   assign rdy[Q_W]  = out_ready;
   assign in_ready  = rdy[0];

   for (genvar s = 0; s < Q_W; s++) begin : g_step
      logic     v_prev;
      dsr_type  r_prev  [LANES];
      quo_type  lo_prev [LANES];
      dsr_type  d_prev  [LANES];
      side_type side_prev;
      dsr_type  r_in    [LANES];
      quo_type  lo_in   [LANES];
      logic [D_W:0] t   [LANES];
      logic     ge      [LANES];

      if (s == 0) begin : g_first
         always_comb begin
            v_prev    = in_valid;
            side_prev = in_side;
            for (int l = 0; l < LANES; l++) begin
               r_prev[l]  = in_n[l][N_W-1:Q_W];
               lo_prev[l] = in_n[l][Q_W-1:0];
               d_prev[l]  = in_d[l];
            end
         end
      end else begin : g_next
         always_comb begin
            v_prev    = v_ff[s-1];
            side_prev = side_ff[s-1];
            r_prev    = r_ff[s-1];
            lo_prev   = lo_ff[s-1];
            d_prev    = d_ff[s-1];
         end
      end

      assign rdy[s] = !v_ff[s] || rdy[s+1];

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            t[l]     = {r_prev[l], lo_prev[l][Q_W-1]};
            ge[l]    = (t[l] >= {1'b0, d_prev[l]});
            r_in[l]  = ge[l] ? D_W'(t[l] - {1'b0, d_prev[l]}) : t[l][D_W-1:0];
            lo_in[l] = {lo_prev[l][Q_W-2:0], ge[l]};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            v_ff[s] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[s]) begin
            r_ff[s]    <= r_in;
            lo_ff[s]   <= lo_in;
            d_ff[s]    <= d_prev;
            side_ff[s] <= side_prev;
         end
      end
   end

   assign out_valid = v_ff[Q_W-1];
   assign out_q     = lo_ff[Q_W-1];
   assign out_side  = side_ff[Q_W-1];

endmodule

@@ hdl/pqd_sqrt.sv @@
// ---------------------------------------------------------------------------
// pqd_sqrt
// digit-by-digit integer square root, one root bit per stage
// ---------------------------------------------------------------------------
module pqd_sqrt import pqd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  quo_type  in_q [LANES],
   input  side_type in_side,
   output logic     out_valid,
   input  logic     out_ready,
   output quo_type  out_q    [LANES],
   output root_type out_root [LANES],
   output side_type out_side
);

   localparam int SH_W = 2 * SQ_STEPS;

   logic             v_ff    [SQ_STEPS];
   logic             rdy     [SQ_STEPS+1];
   logic [REM_W-1:0] rem_ff  [SQ_STEPS][LANES];
   root_type         root_ff [SQ_STEPS][LANES];
   logic [SH_W-1:0]  sh_ff   [SQ_STEPS][LANES];
   quo_type          q_ff    [SQ_STEPS][LANES];
   side_type         side_ff [SQ_STEPS];

   assign rdy[SQ_STEPS] = out_ready;
   assign in_ready      = rdy[0];

   for (genvar s = 0; s < SQ_STEPS; s++) begin : g_step
      logic             v_prev;
      logic [REM_W-1:0] rem_prev  [LANES];
      root_type         root_prev [LANES];
      logic [SH_W-1:0]  sh_prev   [LANES];
      quo_type          q_prev    [LANES];
      side_type         side_prev;
      logic [REM_W+1:0] t         [LANES];
      logic [REM_W+1:0] trial     [LANES];
      logic             ge        [LANES];
      logic [REM_W-1:0] rem_in    [LANES];
      root_type         root_in   [LANES];
      logic [SH_W-1:0]  sh_in     [LANES];

      if (s == 0) begin : g_first
         always_comb begin
            v_prev    = in_valid;
            side_prev = in_side;
            q_prev    = in_q;
            for (int l = 0; l < LANES; l++) begin
               rem_prev[l]  = '0;
               root_prev[l] = '0;
               sh_prev[l]   = SH_W'(in_q[l]);
            end
         end
      end else begin : g_next
         always_comb begin
            v_prev    = v_ff[s-1];
            side_prev = side_ff[s-1];
            q_prev    = q_ff[s-1];
            rem_prev  = rem_ff[s-1];
            root_prev = root_ff[s-1];
            sh_prev   = sh_ff[s-1];
         end
      end

      assign rdy[s] = !v_ff[s] || rdy[s+1];

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            t[l]       = {rem_prev[l], sh_prev[l][SH_W-1 -: 2]};
            trial[l]   = (REM_W+2)'({root_prev[l], 2'b01});
            ge[l]      = (t[l] >= trial[l]);
            rem_in[l]  = ge[l] ? REM_W'(t[l] - trial[l]) : REM_W'(t[l]);
            root_in[l] = {root_prev[l][ROOT_W-2:0], ge[l]};
            sh_in[l]   = {sh_prev[l][SH_W-3:0], 2'b00};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (rdy[s]) begin
            v_ff[s] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[s]) begin
            rem_ff[s]  <= rem_in;
            root_ff[s] <= root_in;
            sh_ff[s]   <= sh_in;
            q_ff[s]    <= q_prev;
            side_ff[s] <= side_prev;
         end
      end
   end

   assign out_valid = v_ff[SQ_STEPS-1];
   assign out_q     = q_ff[SQ_STEPS-1];
   assign out_root  = root_ff[SQ_STEPS-1];
   assign out_side  = side_ff[SQ_STEPS-1];

endmodule

@@ hdl/packed_quaternion_decode.sv @@
// ---------------------------------------------------------------------------
// packed_quaternion_decode
// 11/11/10 packed orientation word to unit quaternion, 16 fraction bits
// ---------------------------------------------------------------------------
//  channel  dir  fields                                         transfer
//  req      in   packed_word, last_row                          valid & ready
//  rsp      out  quat_w/x/y/z, was_normalized, last_out         valid & ready
//
//  one transfer per cycle in and out while rsp is not stalled; pipeline of
//  4 setup stages, 35 divider stages, 18 root stages and an output register
//  every stage has its own valid bit and loads when it is empty or its
//  successor moves, so bubbles close up and a stall on rsp backs up stage
//  by stage without dropping or repeating a transfer
//  reset clears the valid bits only
// ---------------------------------------------------------------------------
module packed_quaternion_decode import pqd_pkg::*; (
   input logic       clock,
   input logic       reset,
   pqd_req_if.sink   req,
   pqd_rsp_if.source rsp
);

   // front end to divider
   logic     fr_valid, fr_ready;
   dvd_type  fr_n [LANES];
   dsr_type  fr_d [LANES];
   side_type fr_side;

   // divider to root
   logic     dv_valid, dv_ready;
   quo_type  dv_q [LANES];
   side_type dv_side;

   // root to output register
   logic     sq_valid, sq_ready;
   quo_type  sq_q    [LANES];
   root_type sq_root [LANES];
   side_type sq_side;

   logic [QV_W-1:0] mag     [LANES];
   logic [ROOT_W:0] root_p1 [LANES];

   logic                   out_v_ff;
   logic signed [QW_W-1:0] w_ff;
   logic signed [QV_W-1:0] x_ff, y_ff, z_ff;
   logic                   norm_ff, last_ff;

   // unpack, squared length, per-lane dividend and divisor
   pqd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_word   (req.packed_word),
      .in_last   (req.last_row),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_n     (fr_n),
      .out_d     (fr_d),
      .out_side  (fr_side)
   );

   // quotient per lane: plain value, or the radicand scaled by the length
   pqd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_n      (fr_n),
      .in_d      (fr_d),
      .in_side   (fr_side),
      .out_valid (dv_valid),
      .out_ready (dv_ready),
      .out_q     (dv_q),
      .out_side  (dv_side)
   );

   // integer square root of every quotient, quotient carried alongside
   pqd_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv_valid),
      .in_ready  (dv_ready),
      .in_q      (dv_q),
      .in_side   (dv_side),
      .out_valid (sq_valid),
      .out_ready (sq_ready),
      .out_q     (sq_q),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // rounded magnitude per lane: w always goes through the root, x/y/z only
   // when normalized; the largest odd 2q-1 under the root gives q
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         root_p1[l] = {1'b0, sq_root[l]} + (ROOT_W+1)'(1);
         if (l == LANE_W || sq_side.norm) begin
            mag[l] = QV_W'(root_p1[l][ROOT_W:1]);
         end else begin
            mag[l] = sq_q[l][QV_W-1:0];
         end
      end
   end

   assign sq_ready = !out_v_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (sq_ready) begin
         out_v_ff <= sq_valid;
      end
   end

   // output register, signs applied here
   always_ff @(posedge clock) begin
      if (sq_ready) begin
         w_ff    <= QW_W'(-mag[LANE_W]);
         x_ff    <= sq_side.neg[0] ? -mag[LANE_X] : mag[LANE_X];
         y_ff    <= sq_side.neg[1] ? -mag[LANE_Y] : mag[LANE_Y];
         z_ff    <= sq_side.neg[2] ? -mag[LANE_Z] : mag[LANE_Z];
         norm_ff <= sq_side.norm;
         last_ff <= sq_side.last;
      end
   end

   assign rsp.valid          = out_v_ff;
   assign rsp.quat_w         = w_ff;
   assign rsp.quat_x         = x_ff;
   assign rsp.quat_y         = y_ff;
   assign rsp.quat_z         = z_ff;
   assign rsp.was_normalized = norm_ff;
   assign rsp.last_out       = last_ff;

endmodule

@@ tb/packed_quaternion_decode_tb.sv @@
// ---------------------------------------------------------------------------
// packed_quaternion_decode_tb
// self-checking bench for the packed quaternion decoder: every accepted
// word is decoded by an exact integer model and compared field by field
// with the in-order result stream under random idle and stall patterns
// ---------------------------------------------------------------------------
module packed_quaternion_decode_tb;
   import pqd_pkg::*;

   typedef struct {
      logic [QW_W-1:0] w;
      logic [QV_W-1:0] x;
      logic [QV_W-1:0] y;
      logic [QV_W-1:0] z;
      logic            norm;
      logic            last;
   } quat_result_type;

   localparam longint unsigned FULL_SQ = 64'(XY_SCALE) * XY_SCALE * Z_SCALE * Z_SCALE;
   localparam int STALL_LIMIT = 3000;   // cycles with no transfer at all
   localparam int DRAIN_TAIL  = 120;    // pipeline is 58 deep

   logic clock;
   logic reset;

   pqd_req_if req_ch();
   pqd_rsp_if rsp_ch();

   packed_quaternion_decode uut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   quat_result_type pending_quats[$];
   int              errors;
   int              send_idle_pct;
   int              stall_pct;
   int              quiet_cycles;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------------------------------------------------------------
   // exact decode model
   // ---------------------------------------------------------------------

   // largest q in [0, 2^FRAC_BITS] with q == 0 or (2q-1)^2 * k <= r,
   // i.e. sqrt(r/k)/2 rounded to nearest
   function automatic longint unsigned nearest_root(longint unsigned k, logic [127:0] r);
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      longint unsigned odd;
      lo = 0;
      hi = longint'(1) << FRAC_BITS;
      while (lo < hi) begin
         mid = lo + (hi - lo + 1) / 2;
         odd = 2 * mid - 1;
         if (128'(odd * odd) * 128'(k) <= r) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      return lo;
   endfunction

   // component divided by the vector length
   function automatic longint normalized_part(longint v, longint unsigned scale,
                                             longint unsigned len_sq);
      longint unsigned mag;
      logic [127:0]    two_a;
      longint unsigned q;
      mag   = (v < 0 ? -v : v) * scale;
      two_a = 128'(mag) << (FRAC_BITS + 1);
      q     = nearest_root(len_sq, two_a * two_a);
      return v < 0 ? -longint'(q) : longint'(q);
   endfunction

   // component v/den rounded to nearest, ties away from zero
   function automatic longint scaled_part(longint v, longint unsigned den);
      longint unsigned mag;
      longint unsigned q;
      mag = v < 0 ? -v : v;
      q   = ((mag << (FRAC_BITS + 1)) + den) / (2 * den);
      return v < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic quat_result_type decode_quat(logic [31:0] word, logic last);
      quat_result_type res;
      longint          xv;
      longint          yv;
      longint          zv;
      longint unsigned len_sq;
      longint          wq;
      xv = longint'(XY_SCALE) - longint'(word[10:0]);
      yv = longint'(XY_SCALE) - longint'(word[21:11]);
      zv = longint'(Z_SCALE) - longint'(word[31:22]);
      // squared length over the common denominator 1023^2 * 511^2
      len_sq = longint'(xv * xv) * Z_SCALE * Z_SCALE + longint'(yv * yv) * Z_SCALE * Z_SCALE
             + longint'(zv * zv) * XY_SCALE * XY_SCALE;
      res.norm = len_sq >= FULL_SQ;
      res.last = last;
      if (res.norm) begin
         res.x = QV_W'(normalized_part(xv, Z_SCALE, len_sq));
         res.y = QV_W'(normalized_part(yv, Z_SCALE, len_sq));
         res.z = QV_W'(normalized_part(zv, XY_SCALE, len_sq));
         res.w = '0;
      end else begin
         res.x = QV_W'(scaled_part(xv, XY_SCALE));
         res.y = QV_W'(scaled_part(yv, XY_SCALE));
         res.z = QV_W'(scaled_part(zv, Z_SCALE));
         wq    = -longint'(nearest_root(FULL_SQ, 128'(FULL_SQ - len_sq) << (2 * FRAC_BITS + 2)));
         res.w = QW_W'(wq);
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // monitors
   // ---------------------------------------------------------------------

   // every accepted word gets its expected quaternion queued
   always @(posedge clock) begin
      if (!reset && req_ch.valid && req_ch.ready) begin
         pending_quats = {pending_quats, decode_quat(req_ch.packed_word, req_ch.last_row)};
      end
   end

   task automatic compare_field(string name, logic [QV_W-1:0] expected, logic [QV_W-1:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, expected, actual);
         errors++;
      end
   endtask

   // results come back in order, so each transfer matches the oldest entry
   always @(posedge clock) begin
      quat_result_type exp_q;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_quats.size() == 0) begin
            $display("%0t: unexpected result transfer, expected none, actual w=%h x=%h y=%h z=%h",
                     $time, rsp_ch.quat_w, rsp_ch.quat_x, rsp_ch.quat_y, rsp_ch.quat_z);
            errors++;
         end else begin
            exp_q = pending_quats.pop_front();
            // w is 17 bits, both sides zero-extended for the compare
            compare_field("quat_w", {1'b0, exp_q.w}, {1'b0, rsp_ch.quat_w});
            compare_field("quat_x", exp_q.x, rsp_ch.quat_x);
            compare_field("quat_y", exp_q.y, rsp_ch.quat_y);
            compare_field("quat_z", exp_q.z, rsp_ch.quat_z);
            compare_field("was_normalized", QV_W'(exp_q.norm), QV_W'(rsp_ch.was_normalized));
            compare_field("last_out", QV_W'(exp_q.last), QV_W'(rsp_ch.last_out));
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   // watchdog: give up when nothing moves on either side for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: watchdog expired with %0d results outstanding",
                  $time, pending_quats.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------

   // one word, with a random gap in front of it, held until the transfer
   task automatic send_word(logic [31:0] word, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.packed_word <= word;
      req_ch.last_row    <= last;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_quats.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pack_word(int rx, int ry, int rz);
      return {10'(rz), 11'(ry), 11'(rx)};
   endfunction

   task automatic test_directed();
      send_word(pack_word(0, 0, 0), 1'b0);            // all +1, normalized
      send_word(32'hffff_ffff, 1'b1);                 // raw maxima, just below -1
      send_word(pack_word(1023, 1023, 511), 1'b0);    // zero vector, w = -1
      send_word(pack_word(0, 1023, 511), 1'b1);       // length exactly one
      send_word(pack_word(1023, 2046, 511), 1'b0);    // y = -1 exactly
      send_word(pack_word(1023, 1023, 1022), 1'b0);   // z = -1 exactly
      send_word(pack_word(2047, 1023, 511), 1'b0);    // x below -1 alone
      send_word(pack_word(1023, 1023, 1023), 1'b1);   // z below -1 alone
      send_word(pack_word(1024, 1022, 510), 1'b0);    // tiny vector
      send_word(pack_word(300, 1023, 511), 1'b0);     // squared length just under one half
      send_word(pack_word(299, 1023, 511), 1'b0);
      send_word(32'haaaa_aaaa, 1'b1);
      send_word(32'h5555_5555, 1'b0);
      send_word(pack_word(1323, 723, 361), 1'b0);
      send_word(pack_word(723, 1323, 661), 1'b1);
      wait_drained();
   endtask

   task automatic test_stream(int count, int idle_pct, int stall);
      logic [31:0] word;
      send_idle_pct = idle_pct;
      stall_pct     = stall;
      repeat (count) begin
         case ($urandom_range(2))
            0: word = $urandom();
            // always inside the unit ball so the root path is exercised
            1: word = pack_word($urandom_range(1450, 596), $urandom_range(1450, 596),
                                $urandom_range(725, 297));
            default: word = pack_word($urandom_range(2047), $urandom_range(2047),
                                      $urandom_range(1023));
         endcase
         send_word(word, $urandom_range(1));
      end
   endtask

   task automatic test_drain_pause();
      test_stream(20, 0, 0);
      // sender holds off until the pipeline is empty, then restarts at full rate
      wait_drained();
      test_stream(20, 0, 0);
   endtask

   initial begin
      errors             = 0;
      send_idle_pct      = 0;
      stall_pct          = 0;
      quiet_cycles       = 0;
      reset              = 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.packed_word <= '0;
      req_ch.last_row    <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_stream(130, 0, 0);
      test_stream(110, 70, 0);
      test_stream(110, 0, 70);
      test_stream(110, 24, 24);
      test_drain_pause();
      test_stream(40, 0, 0);

      wait_drained();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ files.f @@
hdl/pqd_pkg.sv
hdl/pqd_if.sv
hdl/pqd_front.sv
hdl/pqd_div.sv
hdl/pqd_sqrt.sv
hdl/packed_quaternion_decode.sv
tb/packed_quaternion_decode_tb.sv
